[rtl/fqres_pkg.sv]
package fqres_pkg;

	localparam int CPU_COUNT     = 64;
	localparam int TABLE_ENTRIES = 256;

	localparam int CPU_IDX_W = 6;
	localparam int FREQ_W    = 32;
	localparam int CTR_W     = 64;
	localparam int STATUS_W  = 3;

	localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int TAB_W  = $clog2(TABLE_ENTRIES);
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CPU_IDX_N = 1 << CPU_IDX_W;

	typedef logic [CPU_W-1:0]  cpu_t;
	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [CTR_W-1:0]  ctr_t;
	typedef logic [TAB_W-1:0]  tab_addr_t;
	typedef logic [FILL_W-1:0] fill_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FAILED    = 3'd0,
		ST_UNCHANGED = 3'd1,
		ST_FIRST     = 3'd2,
		ST_ACCUM     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		freq_t freq;
		ctr_t  cycles;
		ctr_t  clocks;
	} cpu_entry_t;

	typedef struct packed {
		logic       rd;
		logic       wr;
		cpu_t       addr;
		cpu_entry_t data;
	} cpu_req_t;

	typedef struct packed {
		cpu_t  cpu;
		freq_t freq;
	} key_t;

	typedef struct packed {
		key_t key;
		ctr_t cycles;
		ctr_t clocks;
	} tab_entry_t;

	typedef struct packed {
		logic start;
		key_t key;
		ctr_t dcyc;
		ctr_t dclk;
	} tab_req_t;

	typedef struct packed {
		logic done;
		logic full;
		ctr_t cycles;
		ctr_t clocks;
	} tab_rsp_t;

	typedef logic [CPU_IDX_N-1:0][CPU_W-1:0] cpu_map_t;

	function automatic cpu_map_t build_cpu_map();
		cpu_map_t m;
		for (int i = 0; i < CPU_IDX_N; i++) begin
			m[i] = CPU_W'(i % CPU_COUNT);
		end
		return m;
	endfunction

	localparam cpu_map_t CPU_MAP = build_cpu_map();

	function automatic cpu_t cpu_reduce(input logic [CPU_IDX_W-1:0] idx);
		return CPU_MAP[idx];
	endfunction

endpackage

[rtl/per_cpu_frequency_residency_counter.sv]
// Channel   Handshake             Payload
// input     in_valid / in_ready   cpu_index, new_freq, old_freq, transition_failed,
//                                 cycle_count, clock_count
// output    out_valid / out_ready status, out_cpu, out_freq, cycles_total, clock_total
//
// One item is processed at a time. Ignored and first-record items go from acceptance straight
// to the result state; accumulating items first read the per-CPU store and then search the
// table memory for their key, one entry per cycle over the entries in use. Reset clears the
// per-CPU seen flags and the table fill count; no clearing pass is needed. A stalled output
// holds the finished item, and the next item is accepted meanwhile, waiting only at result
// load.
module per_cpu_frequency_residency_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  cpu_index,
	input  logic [31:0] new_freq,
	input  logic [31:0] old_freq,
	input  logic        transition_failed,
	input  logic [63:0] cycle_count,
	input  logic [63:0] clock_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [5:0]  out_cpu,
	output logic [31:0] out_freq,
	output logic [63:0] cycles_total,
	output logic [63:0] clock_total
);
	import fqres_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_CPU_RD, S_SEARCH, S_RESULT} state_t;

	state_t     state_q;
	cpu_t       cpu_q;
	freq_t      nf_q;
	ctr_t       cyc_q;
	ctr_t       clk_q;
	freq_t      prev_q;
	status_t    res_q;
	logic       out_valid_q;
	status_t    status_q;
	logic [5:0] out_cpu_q;
	freq_t      out_freq_q;
	ctr_t       cycles_total_q;
	ctr_t       clock_total_q;

	logic       in_acc;
	logic       res_load;
	cpu_t       in_cpu;
	logic       seen;
	cpu_req_t   cpu_req;
	cpu_entry_t cpu_rdata;
	tab_req_t   tab_req;
	tab_rsp_t   tab_rsp;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign in_cpu   = cpu_reduce(cpu_index);
	assign res_load = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	always_comb begin
		cpu_req.rd = 1'b0;
		cpu_req.wr = 1'b0;
		if (state_q == S_IDLE) begin
			cpu_req.addr = in_cpu;
			cpu_req.data = '{freq: new_freq, cycles: cycle_count, clocks: clock_count};
		end else begin
			cpu_req.addr = cpu_q;
			cpu_req.data = '{freq: nf_q, cycles: cyc_q, clocks: clk_q};
		end
		if (in_acc && !transition_failed && (new_freq != old_freq)) begin
			cpu_req.wr = !seen;
			cpu_req.rd = seen;
		end
		if (state_q == S_CPU_RD) begin
			cpu_req.wr = 1'b1;
		end
	end

	always_comb begin
		tab_req.start    = (state_q == S_CPU_RD);
		tab_req.key.cpu  = cpu_q;
		tab_req.key.freq = cpu_rdata.freq;
		tab_req.dcyc     = cyc_q - cpu_rdata.cycles;
		tab_req.dclk     = clk_q - cpu_rdata.clocks;
	end

	fqres_cpu_store u_cpu_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cpu_req),
		.seen   (seen),
		.rdata  (cpu_rdata)
	);

	fqres_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tab_req),
		.rsp    (tab_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cpu_q          <= '0;
			nf_q           <= '0;
			cyc_q          <= '0;
			clk_q          <= '0;
			prev_q         <= '0;
			res_q          <= ST_FAILED;
			out_valid_q    <= 1'b0;
			status_q       <= ST_FAILED;
			out_cpu_q      <= '0;
			out_freq_q     <= '0;
			cycles_total_q <= '0;
			clock_total_q  <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cpu_q <= in_cpu;
						nf_q  <= new_freq;
						cyc_q <= cycle_count;
						clk_q <= clock_count;
						if (transition_failed) begin
							res_q   <= ST_FAILED;
							state_q <= S_RESULT;
						end else if (new_freq == old_freq) begin
							res_q   <= ST_UNCHANGED;
							state_q <= S_RESULT;
						end else if (!seen) begin
							res_q   <= ST_FIRST;
							state_q <= S_RESULT;
						end else begin
							state_q <= S_CPU_RD;
						end
					end
				end
				S_CPU_RD: begin
					prev_q  <= cpu_rdata.freq;
					state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					if (tab_rsp.done) begin
						res_q   <= tab_rsp.full ? ST_FULL : ST_ACCUM;
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (res_load) begin
						status_q <= res_q;
						if ((res_q == ST_ACCUM) || (res_q == ST_FULL)) begin
							out_cpu_q      <= 6'(cpu_q);
							out_freq_q     <= prev_q;
							cycles_total_q <= tab_rsp.cycles;
							clock_total_q  <= tab_rsp.clocks;
						end else begin
							out_cpu_q      <= '0;
							out_freq_q     <= '0;
							cycles_total_q <= '0;
							clock_total_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_cpu      = out_cpu_q;
	assign out_freq     = out_freq_q;
	assign cycles_total = cycles_total_q;
	assign clock_total  = clock_total_q;

`ifndef SYNTHESIS
	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tab_rsp.done |-> state_q == S_SEARCH)
		else $error("table response outside of a search");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second item accepted while one is in progress");

	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FAILED || status == ST_UNCHANGED || status == ST_FIRST)
		|-> out_cpu == '0 && cycles_total == '0 && clock_total == '0)
		else $error("non-zero payload on an item without a table update");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> cycles_total == '0 && clock_total == '0)
		else $error("totals reported for a dropped item");
`endif

endmodule

[rtl/fqres_cpu_store.sv]
module fqres_cpu_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fqres_pkg::cpu_req_t    req,
	output logic                   seen,
	output fqres_pkg::cpu_entry_t  rdata
);
	import fqres_pkg::*;

	logic [CPU_COUNT-1:0] seen_q;
	cpu_entry_t           mem [CPU_COUNT];

	assign seen = seen_q[req.addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (req.wr) begin
			seen_q[req.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.data;
		end
		if (req.rd) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

[rtl/fqres_table.sv]
module fqres_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fqres_pkg::tab_req_t  req,
	output fqres_pkg::tab_rsp_t  rsp
);
	import fqres_pkg::*;

	typedef enum logic [1:0] {T_IDLE, T_SCAN, T_UPD} tstate_t;

	tstate_t    state_q;
	fill_t      fill_q;
	fill_t      idx_q;
	logic       rd_vld_s1;
	tab_addr_t  rd_idx_s1;
	tab_entry_t rdata_s1;
	tab_addr_t  slot_q;
	key_t       key_q;
	ctr_t       dcyc_q;
	ctr_t       dclk_q;
	ctr_t       base_cyc_q;
	ctr_t       base_clk_q;
	tab_rsp_t   rsp_q;
	tab_entry_t mem [TABLE_ENTRIES];

	logic rd_en;
	logic wr_en;
	ctr_t sum_cyc;
	ctr_t sum_clk;

	assign rd_en   = (state_q == T_SCAN) && (idx_q < fill_q);
	assign wr_en   = (state_q == T_UPD);
	assign sum_cyc = base_cyc_q + dcyc_q;
	assign sum_clk = base_clk_q + dclk_q;
	assign rsp     = rsp_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[idx_q[TAB_W-1:0]];
		end
		if (wr_en) begin
			mem[slot_q] <= '{key: key_q, cycles: sum_cyc, clocks: sum_clk};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			fill_q     <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			slot_q     <= '0;
			key_q      <= '0;
			dcyc_q     <= '0;
			dclk_q     <= '0;
			base_cyc_q <= '0;
			base_clk_q <= '0;
			rsp_q      <= '0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					rsp_q.done <= 1'b0;
					if (req.start) begin
						key_q     <= req.key;
						dcyc_q    <= req.dcyc;
						dclk_q    <= req.dclk;
						idx_q     <= '0;
						rd_vld_s1 <= 1'b0;
						state_q   <= T_SCAN;
					end
				end
				T_SCAN: begin
					rd_vld_s1 <= rd_en;
					rd_idx_s1 <= idx_q[TAB_W-1:0];
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_vld_s1 && (rdata_s1.key == key_q)) begin
						slot_q     <= rd_idx_s1;
						base_cyc_q <= rdata_s1.cycles;
						base_clk_q <= rdata_s1.clocks;
						state_q    <= T_UPD;
					end else if (!rd_vld_s1 && !rd_en) begin
						if (fill_q == FILL_W'(TABLE_ENTRIES)) begin
							rsp_q   <= '{done: 1'b1, full: 1'b1, cycles: '0, clocks: '0};
							state_q <= T_IDLE;
						end else begin
							slot_q     <= fill_q[TAB_W-1:0];
							fill_q     <= fill_q + 1'b1;
							base_cyc_q <= '0;
							base_clk_q <= '0;
							state_q    <= T_UPD;
						end
					end
				end
				T_UPD: begin
					rsp_q   <= '{done: 1'b1, full: 1'b0, cycles: sum_cyc, clocks: sum_clk};
					state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/tb_per_cpu_frequency_residency_counter.sv]
`timescale 1ns / 100ps

module tb_per_cpu_frequency_residency_counter;
	import fqres_pkg::*;

	typedef struct packed {
		logic [5:0] cpu;
		freq_t      new_f;
		freq_t      old_f;
		logic       failed;
		ctr_t       cycles;
		ctr_t       clocks;
	} freq_change_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] cpu;
		freq_t      freq;
		ctr_t       cycles;
		ctr_t       clocks;
	} residency_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [5:0]  cpu_index = '0;
	logic [31:0] new_freq = '0;
	logic [31:0] old_freq = '0;
	logic        transition_failed = 1'b0;
	logic [63:0] cycle_count = '0;
	logic [63:0] clock_count = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [5:0]  out_cpu;
	logic [31:0] out_freq;
	logic [63:0] cycles_total;
	logic [63:0] clock_total;

	per_cpu_frequency_residency_counter dut (.*);

	always #5 clk = ~clk;

	// Predicted state of the block.
	bit         cpu_seen [CPU_COUNT];
	freq_t      cur_freq [CPU_COUNT];
	ctr_t       run_start_cycles [CPU_COUNT];
	ctr_t       run_start_clocks [CPU_COUNT];
	bit         slot_used [TABLE_ENTRIES];
	logic [37:0] slot_key [TABLE_ENTRIES];
	ctr_t       slot_cycles [TABLE_ENTRIES];
	ctr_t       slot_clocks [TABLE_ENTRIES];

	// What the stimulus side believes each CPU is running at.
	bit         gen_seen [64];
	freq_t      gen_freq [64];
	ctr_t       gen_cycles [64];
	ctr_t       gen_clocks [64];

	freq_t        freq_pool [16];
	int           pool_n = 4;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           mismatches = 0;
	logic         in_taken = 1'b0;
	freq_change_t next_change;
	residency_t   want;

	freq_change_t pending_changes [$];
	residency_t   expected_residency [$];

	function automatic residency_t predict_residency(input freq_change_t ch);
		residency_t  r;
		int unsigned c;
		freq_t       prev;
		ctr_t        dcyc;
		ctr_t        dclk;
		logic [37:0] key;
		int          hit;
		int          free_slot;
		int          slot;
		r = '0;
		r.status = ST_FAILED;
		c = ch.cpu % CPU_COUNT;
		if (ch.failed)
			return r;
		if (ch.new_f == ch.old_f) begin
			r.status = ST_UNCHANGED;
			return r;
		end
		if (!cpu_seen[c]) begin
			cpu_seen[c] = 1'b1;
			cur_freq[c] = ch.new_f;
			run_start_cycles[c] = ch.cycles;
			run_start_clocks[c] = ch.clocks;
			r.status = ST_FIRST;
			return r;
		end
		prev = cur_freq[c];
		dcyc = ch.cycles - run_start_cycles[c];
		dclk = ch.clocks - run_start_clocks[c];
		cur_freq[c] = ch.new_f;
		run_start_cycles[c] = ch.cycles;
		run_start_clocks[c] = ch.clocks;
		key = {6'(c), prev};
		hit = -1;
		free_slot = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (slot_used[i]) begin
				if (slot_key[i] == key && hit < 0)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		slot = (hit >= 0) ? hit : free_slot;
		r.cpu = 6'(c);
		r.freq = prev;
		if (slot < 0) begin
			r.status = ST_FULL;
			return r;
		end
		if (!slot_used[slot]) begin
			slot_used[slot] = 1'b1;
			slot_key[slot] = key;
			slot_cycles[slot] = '0;
			slot_clocks[slot] = '0;
		end
		slot_cycles[slot] += dcyc;
		slot_clocks[slot] += dclk;
		r.status = ST_ACCUM;
		r.cycles = slot_cycles[slot];
		r.clocks = slot_clocks[slot];
		return r;
	endfunction

	function automatic void queue_change(input logic [5:0] cpu, input freq_t nf,
			input freq_t of, input logic failed, input ctr_t cyc, input ctr_t clks);
		freq_change_t ch;
		ch = '{cpu, nf, of, failed, cyc, clks};
		pending_changes.push_back(ch);
		if (!failed && nf != of) begin
			gen_seen[cpu] = 1'b1;
			gen_freq[cpu] = nf;
			gen_cycles[cpu] = cyc;
			gen_clocks[cpu] = clks;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, exp_val);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_residency.size() == 0) begin
				report_mismatch("unexpected result, status", status, 0);
			end else begin
				want = expected_residency.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (out_cpu !== want.cpu)
					report_mismatch("out_cpu", out_cpu, want.cpu);
				if (out_freq !== want.freq)
					report_mismatch("out_freq", out_freq, want.freq);
				if (cycles_total !== want.cycles)
					report_mismatch("cycles_total", cycles_total, want.cycles);
				if (clock_total !== want.clocks)
					report_mismatch("clock_total", clock_total, want.clocks);
			end
		end
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_residency.push_back(predict_residency('{cpu_index, new_freq,
				old_freq, transition_failed, cycle_count, clock_count}));
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (!in_valid || in_taken) begin
			if (pending_changes.size() > 0 && $urandom_range(99) >= idle_pct) begin
				next_change = pending_changes.pop_front();
				cpu_index <= next_change.cpu;
				new_freq <= next_change.new_f;
				old_freq <= next_change.old_f;
				transition_failed <= next_change.failed;
				cycle_count <= next_change.cycles;
				clock_count <= next_change.clocks;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	initial begin
		#50_000_000;
		$display("tb_per_cpu_frequency_residency_counter NOT OK");
		$finish;
	end

	initial begin
		int          roll;
		int          idx;
		logic [5:0]  c;
		freq_t       nf;
		freq_t       of;
		ctr_t        dcyc;
		ctr_t        dclk;
		int          idle_plan [4];
		int          stall_plan [4];
		idle_plan = '{0, 82, 0, 21};
		stall_plan = '{0, 0, 82, 21};
		freq_pool[0] = '0;
		freq_pool[1] = '1;
		for (int k = 2; k < 16; k++)
			freq_pool[k] = $urandom;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_change(6'd63, 32'd0, 32'd0, 1'b1, '1, '1);
		queue_change(6'd0, '1, '1, 1'b0, '0, '0);
		queue_change(6'd0, 32'd7, 32'd9, 1'b1, 64'd1, 64'd2);
		queue_change(6'd0, '1, 32'd0, 1'b0, '0, '1);
		queue_change(6'd63, 32'd0, '1, 1'b0, '1, '0);
		queue_change(6'd0, 32'd1000, '1, 1'b0, 64'd5, 64'd3);
		queue_change(6'd63, '1, 32'd0, 1'b0, 64'd10, '1);
		queue_change(6'd0, '1, 32'd1000, 1'b0, 64'd4, 64'd2);
		queue_change(6'd0, 32'd1000, '1, 1'b0, '1, 64'h8000_0000_0000_0000);
		queue_change(6'd0, 32'd55, 32'd55, 1'b0, 64'd0, 64'd0);
		queue_change(6'd0, 32'd77, 32'd1000, 1'b1, 64'd9, 64'd9);
		queue_change(6'd0, '1, 32'd1000, 1'b0, 64'h7fff_ffff_ffff_ffff, '0);
		queue_change(6'd63, 32'd0, 32'd12345, 1'b0, 64'd20, 64'd30);
		queue_change(6'd31, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, 64'd100, 64'd200);
		queue_change(6'd31, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 64'd150, 64'd90);

		for (int phase = 0; phase < 4; phase++) begin
			// The sender holds back here until the block has answered everything.
			while (pending_changes.size() > 0 || in_valid || expected_residency.size() > 0)
				@(posedge clk);
			idle_pct = idle_plan[phase];
			stall_pct = stall_plan[phase];
			pool_n = (phase < 3) ? 4 : 16;
			for (int n = 0; n < 500; n++) begin
				roll = $urandom_range(99);
				c = 6'($urandom_range(63));
				if (roll < 6) begin
					queue_change(c, $urandom, $urandom, 1'b1, {$urandom, $urandom},
						{$urandom, $urandom});
				end else if (roll < 11) begin
					nf = (roll < 8) ? freq_pool[$urandom_range(pool_n - 1)] : $urandom;
					queue_change(c, nf, nf, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
				end else begin
					of = gen_seen[c] ? gen_freq[c] : freq_pool[$urandom_range(pool_n - 1)];
					if (roll < 15)
						of = $urandom;
					idx = $urandom_range(pool_n - 1);
					while (freq_pool[idx] == of)
						idx = $urandom_range(pool_n - 1);
					nf = freq_pool[idx];
					roll = $urandom_range(99);
					dcyc = (roll < 70) ? 64'($urandom_range(1, 1_000_000)) :
						(roll < 90) ? {$urandom, $urandom} : -64'($urandom_range(1000));
					roll = $urandom_range(99);
					dclk = (roll < 70) ? 64'($urandom_range(1, 1_000_000)) :
						(roll < 90) ? {$urandom, $urandom} : -64'($urandom_range(1000));
					queue_change(c, nf, of, 1'b0, gen_cycles[c] + dcyc, gen_clocks[c] + dclk);
				end
			end
		end

		while (pending_changes.size() > 0 || in_valid || expected_residency.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (expected_residency.size() != 0)
			report_mismatch("missing results", 0, expected_residency.size());
		if (mismatches == 0)
			$display("tb_per_cpu_frequency_residency_counter OK");
		else
			$display("tb_per_cpu_frequency_residency_counter NOT OK");
		$finish;
	end

endmodule
